### src/bcc_pkg.sv
// shared constants, operation codes and divider handshake types for the coulomb counter
`timescale 1ns / 1ps
`default_nettype none
package bcc_pkg;

   // operation codes carried in the request tuser
   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_CURRENT = 3'd1;
   localparam logic [2:0] OP_SOC     = 3'd2;
   localparam logic [2:0] OP_RUNTIME = 3'd3;
   localparam logic [2:0] OP_VOLTAGE = 3'd4;

   // field widths
   localparam int OP_W      = 3;
   localparam int SAMPLE_W  = 12;
   localparam int AMPS_W    = 10;
   localparam int PEAK_W    = 9;
   localparam int PCT_W     = 7;
   localparam int MIN_W     = 24;
   localparam int VOLTS_W   = 8;
   localparam int CFG_W     = 32;

   localparam int REQ_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_BITS   = AMPS_W + PEAK_W + PCT_W + MIN_W + VOLTS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // state widths
   localparam int ACC_W = 40;
   localparam int REM_W = 48;
   localparam int DIV_W = (ACC_W > REM_W) ? ACC_W : REM_W;
   localparam int CNT_W = $clog2(DIV_W);

   // arithmetic constants
   localparam int AMPS_GAIN   = 1612;
   localparam int AMPS_OFFSET = 3200000;
   localparam int AMPS_DIV    = 7600;
   localparam int SOC_DIV     = 1000;
   localparam int PCT_DIV     = 100;
   localparam int AVG_DIV     = 100;
   localparam int MIN_DIV     = 60000;
   localparam int VOLT_DIV    = 100;
   localparam int PCT_MAX     = 100;
   localparam int MIN_MAX     = 16777215;
   localparam logic [CFG_W-1:0] CAPACITY_RESET = 32'd3600000;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

### src/bcc_divider.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bcc_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bcc_pkg::div_req_type div_req,
   output bcc_pkg::div_rsp_type    div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bcc_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bcc_pkg::DIV_W-1:0]     part_ff, part_in;
   logic [bcc_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [bcc_pkg::DIV_W-1:0]     dsr_ff, dsr_in;
   logic [bcc_pkg::DIV_W:0]       trial;

   assign trial = {part_ff, quo_ff[bcc_pkg::DIV_W-1]} - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      part_in = part_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         part_in = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[bcc_pkg::DIV_W]) begin
            part_in = trial[bcc_pkg::DIV_W-1:0];
            quo_in  = {quo_ff[bcc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            part_in = {part_ff[bcc_pkg::DIV_W-2:0], quo_ff[bcc_pkg::DIV_W-1]};
            quo_in  = {quo_ff[bcc_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + bcc_pkg::CNT_W'(1);
         if (cnt_ff == bcc_pkg::CNT_W'(bcc_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      part_ff <= part_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

### src/battery_coulomb_counter_unit.sv
// coulomb counting fuel gauge: sequencer, gauge state and result register
// init and unknown operations need no division; voltage and current need one, soc update two or three,
// runtime query one or three, run one after another
// a division is issued to the shared serial divider, which forms the 48-bit quotient, and handed back
// one item at a time; the next is taken in the cycle after its result enters the free output register
// reset is synchronous: capacity register to 3600000, gauge state cleared, charge reloaded
`timescale 1ns / 1ps
`default_nettype none
module battery_coulomb_counter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bcc_pkg::REQ_DATA_W-1:0]    req_tdata,  // sample
   input  wire logic [bcc_pkg::OP_W-1:0]          req_tuser,  // operation
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bcc_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // amps, peak_amps, charge_percent, minutes, volts
   output logic                                   rsp_tuser,  // minutes_valid
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bcc_pkg::CFG_W-1:0]         csr_wdata   // capacity
);

   localparam int AMPS_W = bcc_pkg::AMPS_W;
   localparam int ACC_W  = bcc_pkg::ACC_W;
   localparam int REM_W  = bcc_pkg::REM_W;
   localparam int DIV_W  = bcc_pkg::DIV_W;
   localparam int R_W    = DIV_W + 2;
   localparam int PROD_W = bcc_pkg::SAMPLE_W + 11;
   localparam int VOLT_W = bcc_pkg::SAMPLE_W + 2;
   localparam int INC_W  = AMPS_W + 4;
   localparam int PAD_W  = bcc_pkg::RSP_DATA_W - bcc_pkg::RSP_BITS;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CUR_DIV = 4'd1;
   localparam logic [3:0] ST_CUR_ACC = 4'd2;
   localparam logic [3:0] ST_SOC_D1  = 4'd3;
   localparam logic [3:0] ST_SOC_D2  = 4'd4;
   localparam logic [3:0] ST_SOC_D3  = 4'd5;
   localparam logic [3:0] ST_RUN_D1  = 4'd6;
   localparam logic [3:0] ST_RUN_D2  = 4'd7;
   localparam logic [3:0] ST_RUN_D3  = 4'd8;
   localparam logic [3:0] ST_VOLT_D  = 4'd9;
   localparam logic [3:0] ST_OUT     = 4'd10;

   localparam logic signed [R_W-1:0] R_MAX =
      {{(R_W - REM_W + 1){1'b0}}, {(REM_W - 1){1'b1}}};
   localparam logic signed [R_W-1:0] R_MIN =
      {{(R_W - REM_W + 1){1'b1}}, {(REM_W - 1){1'b0}}};
   localparam logic signed [REM_W-1:0] REM_MAX = {1'b0, {(REM_W - 1){1'b1}}};
   localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

   // control
   logic [3:0]                       state_ff, state_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bcc_pkg::div_req_type             div_req_ff, div_req_in;
   bcc_pkg::div_rsp_type             div_rsp;

   // gauge state
   logic [bcc_pkg::CFG_W-1:0]        full_ff, full_in;
   logic signed [AMPS_W-1:0]         prev_ff, prev_in;
   logic [bcc_pkg::PEAK_W-1:0]       peak_ff, peak_in;
   logic signed [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [REM_W-1:0]          rem_ff, rem_in;
   logic [bcc_pkg::PCT_W-1:0]        pct_ff, pct_in;

   // per item working values
   logic                             neg_ff, neg_in;
   logic signed [AMPS_W-1:0]         amps_ff, amps_in;
   logic [bcc_pkg::MIN_W-1:0]        min_ff, min_in;
   logic                             mvalid_ff, mvalid_in;
   logic [bcc_pkg::VOLTS_W-1:0]      volts_ff, volts_in;
   logic [bcc_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                             rsp_user_ff, rsp_user_in;

   // datapath
   logic [bcc_pkg::SAMPLE_W-1:0]     sample;
   logic [PROD_W-1:0]                cur_prod;
   logic signed [PROD_W:0]           cur_num;
   logic [PROD_W-1:0]                cur_mag;
   logic [ACC_W-1:0]                 acc_mag;
   logic [VOLT_W-1:0]                volt_sum;
   logic [AMPS_W-1:0]                q_amps;
   logic signed [AMPS_W:0]           pair_sum;
   logic signed [AMPS_W:0]           half;
   logic signed [INC_W-1:0]          inc;
   logic signed [ACC_W:0]            acc_sum;
   logic signed [ACC_W-1:0]          acc_sat;
   logic [AMPS_W-1:0]                amps_abs;
   logic signed [R_W-1:0]            rem_ext;
   logic signed [R_W-1:0]            soc_r;
   logic signed [REM_W-1:0]          soc_sat;
   logic                             rem_pos;

   bcc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign sample   = req_tdata[bcc_pkg::SAMPLE_W-1:0];
   assign cur_prod = PROD_W'(sample) * PROD_W'(bcc_pkg::AMPS_GAIN);
   assign cur_num  = $signed({1'b0, cur_prod}) - $signed((PROD_W + 1)'(bcc_pkg::AMPS_OFFSET));
   assign cur_mag  = cur_num[PROD_W] ? PROD_W'(-cur_num) : cur_num[PROD_W-1:0];
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign volt_sum = (VOLT_W'(sample) << 1) + VOLT_W'(sample) + VOLT_W'(sample >> 2);

   assign q_amps   = div_rsp.quotient[AMPS_W-1:0];
   assign pair_sum = (AMPS_W + 1)'(prev_ff) + (AMPS_W + 1)'(amps_ff);
   assign half     = pair_sum[AMPS_W] ? ((pair_sum + (AMPS_W + 1)'(1)) >>> 1)
                                      : (pair_sum >>> 1);
   assign inc      = (INC_W'(half) <<< 3) + (INC_W'(half) <<< 1);
   assign acc_sum  = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(inc);
   assign acc_sat  = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
                     (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];
   assign amps_abs = amps_ff[AMPS_W-1] ? AMPS_W'(-amps_ff) : AMPS_W'(amps_ff);

   assign rem_ext  = R_W'(rem_ff);
   assign soc_r    = neg_ff ? rem_ext + $signed(R_W'(div_rsp.quotient))
                            : rem_ext - $signed(R_W'(div_rsp.quotient));
   assign soc_sat  = (soc_r > R_MAX) ? REM_MAX :
                     (soc_r < R_MIN) ? REM_MIN : soc_r[REM_W-1:0];
   assign rem_pos  = !rem_ff[REM_W-1] && (rem_ff != '0);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      div_req_in    = div_req_ff;
      div_req_in.start = 1'b0;
      full_in       = full_ff;
      prev_in       = prev_ff;
      peak_in       = peak_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      pct_in        = pct_ff;
      neg_in        = neg_ff;
      amps_in       = amps_ff;
      min_in        = min_ff;
      mvalid_in     = mvalid_ff;
      volts_in      = volts_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_valid) begin
         full_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               amps_in   = '0;
               min_in    = '0;
               mvalid_in = 1'b0;
               volts_in  = '0;
               unique case (req_tuser)
                  bcc_pkg::OP_INIT: begin
                     prev_in  = '0;
                     peak_in  = '0;
                     acc_in   = '0;
                     rem_in   = REM_W'(full_ff);
                     pct_in   = '0;
                     state_in = ST_OUT;
                  end
                  bcc_pkg::OP_CURRENT: begin
                     neg_in              = cur_num[PROD_W];
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = DIV_W'(cur_mag);
                     div_req_in.divisor  = DIV_W'(bcc_pkg::AMPS_DIV);
                     state_in            = ST_CUR_DIV;
                  end
                  bcc_pkg::OP_SOC: begin
                     neg_in              = acc_ff[ACC_W-1];
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = DIV_W'(acc_mag);
                     div_req_in.divisor  = DIV_W'(bcc_pkg::SOC_DIV);
                     state_in            = ST_SOC_D1;
                  end
                  bcc_pkg::OP_RUNTIME: begin
                     neg_in              = acc_ff[ACC_W-1];
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = DIV_W'(acc_mag);
                     div_req_in.divisor  = DIV_W'(bcc_pkg::AVG_DIV);
                     state_in            = ST_RUN_D1;
                  end
                  bcc_pkg::OP_VOLTAGE: begin
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = DIV_W'(volt_sum);
                     div_req_in.divisor  = DIV_W'(bcc_pkg::VOLT_DIV);
                     state_in            = ST_VOLT_D;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_CUR_DIV: begin
            if (div_rsp.done) begin
               amps_in  = neg_ff ? -$signed(q_amps) : $signed(q_amps);
               state_in = ST_CUR_ACC;
            end
         end
         ST_CUR_ACC: begin
            acc_in  = acc_sat;
            prev_in = amps_ff;
            if (amps_abs[bcc_pkg::PEAK_W-1:0] > peak_ff) begin
               peak_in = amps_abs[bcc_pkg::PEAK_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_SOC_D1: begin
            if (div_rsp.done) begin
               rem_in              = soc_sat;
               acc_in              = '0;
               div_req_in.start    = 1'b1;
               div_req_in.dividend = DIV_W'(full_ff);
               div_req_in.divisor  = DIV_W'(bcc_pkg::PCT_DIV);
               state_in            = ST_SOC_D2;
            end
         end
         ST_SOC_D2: begin
            if (div_rsp.done) begin
               if (!rem_pos) begin
                  pct_in   = '0;
                  state_in = ST_OUT;
               end else if (div_rsp.quotient == '0) begin
                  pct_in   = bcc_pkg::PCT_W'(bcc_pkg::PCT_MAX);
                  state_in = ST_OUT;
               end else begin
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = DIV_W'(unsigned'(rem_ff));
                  div_req_in.divisor  = div_rsp.quotient;
                  state_in            = ST_SOC_D3;
               end
            end
         end
         ST_SOC_D3: begin
            if (div_rsp.done) begin
               pct_in = (div_rsp.quotient > DIV_W'(bcc_pkg::PCT_MAX)) ?
                        bcc_pkg::PCT_W'(bcc_pkg::PCT_MAX) :
                        div_rsp.quotient[bcc_pkg::PCT_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_RUN_D1: begin
            if (div_rsp.done) begin
               if (neg_ff || div_rsp.quotient == '0) begin
                  state_in = ST_OUT;
               end else if (!rem_pos) begin
                  mvalid_in = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  mvalid_in           = 1'b1;
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = DIV_W'(unsigned'(rem_ff));
                  div_req_in.divisor  = div_rsp.quotient;
                  state_in            = ST_RUN_D2;
               end
            end
         end
         ST_RUN_D2: begin
            if (div_rsp.done) begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = div_rsp.quotient;
               div_req_in.divisor  = DIV_W'(bcc_pkg::MIN_DIV);
               state_in            = ST_RUN_D3;
            end
         end
         ST_RUN_D3: begin
            if (div_rsp.done) begin
               min_in = (div_rsp.quotient > DIV_W'(bcc_pkg::MIN_MAX)) ?
                        bcc_pkg::MIN_W'(bcc_pkg::MIN_MAX) :
                        div_rsp.quotient[bcc_pkg::MIN_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_VOLT_D: begin
            if (div_rsp.done) begin
               volts_in = div_rsp.quotient[bcc_pkg::VOLTS_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, volts_ff, min_ff, pct_ff, peak_ff,
                               unsigned'(amps_ff)};
               rsp_user_in  = mvalid_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_req_ff   <= '0;
         full_ff      <= bcc_pkg::CAPACITY_RESET;
         prev_ff      <= '0;
         peak_ff      <= '0;
         acc_ff       <= '0;
         rem_ff       <= REM_W'(bcc_pkg::CAPACITY_RESET);
         pct_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
         full_ff      <= full_in;
         prev_ff      <= prev_in;
         peak_ff      <= peak_in;
         acc_ff       <= acc_in;
         rem_ff       <= rem_in;
         pct_ff       <= pct_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      amps_ff     <= amps_in;
      min_ff      <= min_in;
      mvalid_ff   <= mvalid_in;
      volts_ff    <= volts_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

### verif/tb_battery_coulomb_counter_unit.sv
// testbench for the coulomb counter: directed and random items checked against a gauge predictor
`timescale 1ns / 1ps
module tb_battery_coulomb_counter_unit;
   import bcc_pkg::*;

   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_LAST      = 3'd7;
   localparam int PEAK_LSB  = AMPS_W;
   localparam int PCT_LSB   = PEAK_LSB + PEAK_W;
   localparam int MIN_LSB   = PCT_LSB + PCT_W;
   localparam int VOLTS_LSB = MIN_LSB + MIN_W;
   localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint REM_HI = (longint'(1) <<< (REM_W - 1)) - 1;
   localparam longint REM_LO = -REM_HI - 1;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 200;
   localparam int CYCLE_LIMIT = 800000;

   typedef struct packed {
      logic [AMPS_W-1:0]  amps;
      logic [PEAK_W-1:0]  peak;
      logic [PCT_W-1:0]   pct;
      logic [MIN_W-1:0]   minutes;
      logic               minutes_ok;
      logic [VOLTS_W-1:0] volts;
   } gauge_reading_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} stall_mode_type;
   typedef enum {SAMPLES_ANY, SAMPLES_DRAIN, SAMPLES_CHARGE} sample_bias_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // sample
   logic [OP_W-1:0]       req_tuser;  // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // amps, peak_amps, charge_percent, minutes, volts
   logic                  rsp_tuser;  // minutes_valid
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_wdata;  // capacity

   battery_coulomb_counter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // gauge state as predicted
   logic [CFG_W-1:0] capacity_reg;
   int               prev_amps;
   int               peak_mag;
   longint           accum;
   longint           charge_left;
   int               last_pct;

   gauge_reading_type expected_readings[$];
   int                error_count;
   int                cycle_count;
   int                burst_left;
   bit                hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic gauge_reading_type gauge_step(input logic [2:0] op,
                                                    input logic [11:0] raw);
      gauge_reading_type res;
      int                s;
      int                amps_now;
      int                mag;
      longint            step;
      longint            charge;
      longint            unit;
      longint            quot;
      longint            avg;
      res = '0;
      s = raw;
      case (op)
         OP_INIT: begin
            prev_amps = 0;
            peak_mag = 0;
            accum = 0;
            charge_left = capacity_reg;
            last_pct = 0;
         end
         OP_CURRENT: begin
            amps_now = (s * AMPS_GAIN - AMPS_OFFSET) / AMPS_DIV;
            step = ((prev_amps + amps_now) / 2) * 10;
            if (step > 0 && accum > ACC_HI - step) begin
               accum = ACC_HI;
            end else if (step < 0 && accum < ACC_LO - step) begin
               accum = ACC_LO;
            end else begin
               accum = accum + step;
            end
            prev_amps = amps_now;
            mag = (amps_now < 0) ? -amps_now : amps_now;
            if (mag > peak_mag) begin
               peak_mag = mag;
            end
            res.amps = amps_now[AMPS_W-1:0];
         end
         OP_SOC: begin
            charge = charge_left - accum / SOC_DIV;
            unit = capacity_reg / 32'd100;
            if (charge > REM_HI) begin
               charge = REM_HI;
            end
            if (charge < REM_LO) begin
               charge = REM_LO;
            end
            charge_left = charge;
            accum = 0;
            if (charge <= 0) begin
               last_pct = 0;
            end else if (unit == 0) begin
               last_pct = PCT_MAX;
            end else begin
               quot = charge / unit;
               last_pct = (quot > PCT_MAX) ? PCT_MAX : int'(quot);
            end
         end
         OP_RUNTIME: begin
            avg = accum / AVG_DIV;
            if (avg > 0) begin
               quot = (charge_left / avg) / MIN_DIV;
               if (quot < 0) begin
                  quot = 0;
               end
               if (quot > MIN_MAX) begin
                  quot = MIN_MAX;
               end
               res.minutes = quot[MIN_W-1:0];
               res.minutes_ok = 1'b1;
            end
         end
         OP_VOLTAGE: begin
            res.volts = VOLTS_W'((s * 3 + s / 4) / VOLT_DIV);
         end
         default: begin
         end
      endcase
      res.peak = peak_mag[PEAK_W-1:0];
      res.pct = last_pct[PCT_W-1:0];
      return res;
   endfunction

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_readings
      gauge_reading_type want;
      gauge_reading_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.amps = rsp_tdata[AMPS_W-1:0];
         got.peak = rsp_tdata[PEAK_LSB +: PEAK_W];
         got.pct = rsp_tdata[PCT_LSB +: PCT_W];
         got.minutes = rsp_tdata[MIN_LSB +: MIN_W];
         got.volts = rsp_tdata[VOLTS_LSB +: VOLTS_W];
         got.minutes_ok = rsp_tuser;
         if (expected_readings.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            compare_field("amps", $signed(want.amps), $signed(got.amps));
            compare_field("peak_amps", want.peak, got.peak);
            compare_field("charge_percent", want.pct, got.pct);
            compare_field("minutes", want.minutes, got.minutes);
            compare_field("minutes_valid", want.minutes_ok, got.minutes_ok);
            compare_field("volts", want.volts, got.volts);
         end
      end
   end

   // receiver stalls in segments, with a long hold-off when a test requests one
   initial begin : rsp_stall_pattern
      int             seg_left;
      int             hold_left;
      stall_mode_type mode;
      rsp_tready = 1'b0;
      seg_left = 0;
      hold_left = 0;
      mode = RDY_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (mode)
               RDY_ALWAYS:  rsp_tready <= 1'b1;
               RDY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               RDY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= (seg_left % 3 != 0);
            endcase
         end
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [11:0] raw);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_DATA_W - SAMPLE_W){1'b0}}, raw};
      do @(posedge clock); while (!req_tready);
      expected_readings.push_back(gauge_step(op, raw));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [11:0] pick_sample(input sample_bias_type bias);
      case (bias)
         SAMPLES_DRAIN:  return 12'($urandom_range(2600, 4095));
         SAMPLES_CHARGE: return 12'($urandom_range(0, 1500));
         default:        return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic test_reset_state();
      send_item(OP_RUNTIME, 12'h000);
      send_item(OP_SOC, 12'hfff);
      send_item(OP_SPARE_LO, 12'hfff);
      send_item(OP_SPARE_MID, 12'h000);
      send_item(OP_LAST, 12'haaa);
      wait_idle();
   endtask

   task automatic test_directed_ops();
      send_item(OP_VOLTAGE, 12'h000);
      send_item(OP_VOLTAGE, 12'hfff);
      send_item(OP_VOLTAGE, 12'h555);
      send_item(OP_VOLTAGE, 12'haaa);
      send_item(OP_CURRENT, 12'h000);
      send_item(OP_CURRENT, 12'hfff);
      send_item(OP_CURRENT, 12'd1985);
      send_item(OP_CURRENT, 12'h555);
      send_item(OP_CURRENT, 12'haaa);
      send_item(OP_RUNTIME, 12'h000);
      send_item(OP_SOC, 12'h000);
      send_item(OP_RUNTIME, 12'h000);
      send_item(OP_INIT, 12'hfff);
      send_item(OP_CURRENT, 12'hfff);
      send_item(OP_CURRENT, 12'hfff);
      send_item(OP_RUNTIME, 12'h000);
      send_item(OP_SOC, 12'h000);
      wait_idle();
   endtask

   task automatic test_output_hold();
      hold_request = 1'b1;
      repeat (12) send_item(OP_CURRENT, 12'($urandom_range(0, 4095)));
      wait_idle();
   endtask

   // charge is not reloaded until init, so an update runs before it
   task automatic test_random_phase(input logic [CFG_W-1:0] charge_cfg, input int items,
                                    input sample_bias_type bias);
      int          pick;
      logic [2:0]  op;
      logic [11:0] raw;
      wait_idle();
      write_capacity(charge_cfg);
      send_item(OP_SOC, 12'h000);
      send_item(OP_INIT, 12'h000);
      repeat (items) begin
         pick = $urandom_range(0, 99);
         raw = pick_sample(SAMPLES_ANY);
         if (pick < 52) begin
            op = OP_CURRENT;
            raw = pick_sample(bias);
         end else if (pick < 65) begin
            op = OP_SOC;
         end else if (pick < 78) begin
            op = OP_RUNTIME;
         end else if (pick < 90) begin
            op = OP_VOLTAGE;
         end else if (pick < 92) begin
            op = OP_INIT;
         end else begin
            op = 3'($urandom_range(OP_SPARE_LO, OP_LAST));
         end
         send_item(op, raw);
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      hold_request = 1'b0;
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      capacity_reg = CAPACITY_RESET;
      void'(gauge_step(OP_INIT, 12'h000));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_ops();
      test_output_hold();
      test_random_phase(CAPACITY_RESET, 100, SAMPLES_ANY);
      test_random_phase(32'd100, 100, SAMPLES_DRAIN);
      test_random_phase(32'hffff_ffff, 100, SAMPLES_CHARGE);
      test_random_phase($urandom_range(150, 400), 100, SAMPLES_DRAIN);
      test_random_phase($urandom, 100, SAMPLES_ANY);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
